### rtl/lcbs_pkg.sv
// shared types and constants for the led cube bit-plane scan-out block
package lcbs_pkg;

  localparam int unsigned EDGE_LEN = 12;
  localparam int unsigned PAD_BITS = 12;
  localparam int unsigned CELLS    = EDGE_LEN * EDGE_LEN * EDGE_LEN;
  localparam int unsigned ADDR_W   = $clog2(CELLS);
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned DATA_W   = 3 * EDGE_LEN;
  localparam int unsigned WORD_W   = DATA_W + PAD_BITS;

  localparam logic [2:0] OP_POINT   = 3'd0;
  localparam logic [2:0] OP_PLANE_X = 3'd1;
  localparam logic [2:0] OP_PLANE_Y = 3'd2;
  localparam logic [2:0] OP_PLANE_Z = 3'd3;
  localparam logic [2:0] OP_FILL    = 3'd4;
  localparam logic [2:0] OP_SCAN    = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] z_pos;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] scan_slice;
    logic [2:0] bit_index;
  } lcbs_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] lane_a_bits;
    logic [WORD_W-1:0] lane_b_bits;
    logic [WORD_W-1:0] lane_c_bits;
    logic [1:0]        face_index;
    logic              latch_strobe;
    logic              last_word;
  } lcbs_res_t;

endpackage

### rtl/lcbs_ram.sv
// generic single-port ram with registered read
module lcbs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1728
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/led_cube_bitplane_scanout.sv
// top level: voxel store, write sequencer and bit-plane scan-out
//
// A request is taken when start_i is high and busy_o is low. Point writes, plane
// writes and full fills make one store access per cycle through the single-port
// voxel ram. A scan makes one voxel read per cycle and gives four results; each
// result is on result_o for one cycle with res_valid_o high and must be taken
// then, as the block cannot be held off. After reset the block runs a clearing
// pass over the store with busy_o high.
module led_cube_bitplane_scanout (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lcbs_pkg::lcbs_req_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output lcbs_pkg::lcbs_res_t result_o
);
  import lcbs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  localparam logic [3:0] LAST_POS = 4'(EDGE_LEN - 1);

  function automatic logic [3:0] mod_edge(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  qm;
    logic [7:0]  r;
    p  = 16'(v) * 16'd171;
    q  = p[15:11];
    qm = 8'({q, 3'b000}) + 8'({q, 2'b00});
    r  = v - qm;
    return r[3:0];
  endfunction

  logic [1:0]       state_q, state_d;
  logic [2:0]       step_q, step_d;
  logic [3:0]       cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [RGB_W-1:0] wdata_q, wdata_d;
  logic [1:0]       lane_q, lane_d, face_q, face_d;
  logic [2:0]       bit_q, bit_d;
  logic             blank_q, blank_d;

  logic             rd_valid_q, rd_end_q;
  logic [1:0]       rd_lane_q, rd_face_q;
  logic [DATA_W-1:0] sr_a_q, sr_b_q, sr_c_q;
  logic             out_valid_q;
  lcbs_res_t        out_q;

  logic             accept;
  logic [3:0]       slice_r;
  logic [3:0]       y_sel;
  logic [ADDR_W-1:0] mem_addr;
  logic             mem_en, mem_we;
  logic [RGB_W-1:0] mem_rdata;
  logic             carry_x, carry_y, carry_z;
  logic [2:0]       rd_bits;
  logic [DATA_W-1:0] sr_c_next;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);
  assign slice_r = (req_i.scan_slice >= 4'(EDGE_LEN)) ?
                   req_i.scan_slice - 4'(EDGE_LEN) : req_i.scan_slice;

  assign y_sel = (state_q == ST_SCAN) ? ({lane_q, 2'b00} + {2'b00, face_q}) : cy_q;
  assign mem_addr = ADDR_W'(cx_q)
                  + ADDR_W'({y_sel, 3'b000}) + ADDR_W'({y_sel, 2'b00})
                  + ADDR_W'({cz_q, 7'd0}) + ADDR_W'({cz_q, 4'd0});
  assign mem_we = (state_q == ST_WRITE);
  assign mem_en = mem_we || (state_q == ST_SCAN);

  lcbs_ram #(
    .WIDTH(RGB_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(wdata_q),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    wdata_d = wdata_q;
    lane_d  = lane_q;
    face_d  = face_q;
    bit_d   = bit_q;
    blank_d = blank_q;
    carry_x = 1'b1;
    carry_y = 1'b1;
    carry_z = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wdata_d = {req_i.red, req_i.green, req_i.blue};
          case (req_i.op)
            OP_POINT:   step_d = 3'b000;
            OP_PLANE_X: step_d = 3'b110;
            OP_PLANE_Y: step_d = 3'b101;
            OP_PLANE_Z: step_d = 3'b011;
            default:    step_d = 3'b111;
          endcase
          cx_d = step_d[0] ? 4'd0 : mod_edge(req_i.x_pos);
          cy_d = step_d[1] ? 4'd0 : mod_edge(req_i.y_pos);
          cz_d = step_d[2] ? 4'd0 : mod_edge(req_i.z_pos);
          if (req_i.op <= OP_FILL) begin
            state_d = ST_WRITE;
          end else if (req_i.op == OP_SCAN) begin
            state_d = ST_SCAN;
            cx_d    = LAST_POS - slice_r;
            cz_d    = LAST_POS;
            lane_d  = 2'd0;
            face_d  = 2'd0;
            bit_d   = req_i.bit_index;
            blank_d = (req_i.bit_index < 3'd2);
          end
        end
      end
      ST_WRITE: begin
        if (step_q[0]) begin
          carry_x = (cx_q == LAST_POS);
          cx_d    = carry_x ? 4'd0 : cx_q + 4'd1;
        end
        carry_y = carry_x;
        if (step_q[1] && carry_x) begin
          carry_y = (cy_q == LAST_POS);
          cy_d    = carry_y ? 4'd0 : cy_q + 4'd1;
        end
        carry_z = carry_y;
        if (step_q[2] && carry_y) begin
          carry_z = (cz_q == LAST_POS);
          cz_d    = carry_z ? 4'd0 : cz_q + 4'd1;
        end
        if (carry_z) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cz_q == 4'd0) begin
          cz_d = LAST_POS;
          if (lane_q == 2'd2) begin
            lane_d = 2'd0;
            face_d = face_q + 2'd1;
            if (face_q == 2'd3) begin
              state_d = ST_IDLE;
            end
          end else begin
            lane_d = lane_q + 2'd1;
          end
        end else begin
          cz_d = cz_q - 4'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // reset starts a fill with zero
      state_q <= ST_WRITE;
      step_q  <= 3'b111;
      cx_q    <= 4'd0;
      cy_q    <= 4'd0;
      cz_q    <= 4'd0;
      wdata_q <= '0;
      lane_q  <= 2'd0;
      face_q  <= 2'd0;
      bit_q   <= 3'd0;
      blank_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      cz_q    <= cz_d;
      wdata_q <= wdata_d;
      lane_q  <= lane_d;
      face_q  <= face_d;
      bit_q   <= bit_d;
      blank_q <= blank_d;
      rd_valid_q  <= (state_q == ST_SCAN);
      out_valid_q <= rd_valid_q && rd_end_q;
    end
  end

  assign rd_bits = {mem_rdata[8 + bit_q], mem_rdata[bit_q], mem_rdata[16 + bit_q]};
  assign sr_c_next = {sr_c_q[DATA_W-4:0], rd_bits};

  always_ff @(posedge clk_i) begin
    rd_lane_q <= lane_q;
    rd_face_q <= face_q;
    rd_end_q  <= (lane_q == 2'd2) && (cz_q == 4'd0);
    if (rd_valid_q) begin
      case (rd_lane_q)
        2'd0:    sr_a_q <= {sr_a_q[DATA_W-4:0], rd_bits};
        2'd1:    sr_b_q <= {sr_b_q[DATA_W-4:0], rd_bits};
        default: sr_c_q <= sr_c_next;
      endcase
      if (rd_end_q) begin
        out_q.lane_a_bits  <= blank_q ? '0 : WORD_W'(sr_a_q);
        out_q.lane_b_bits  <= blank_q ? '0 : WORD_W'(sr_b_q);
        out_q.lane_c_bits  <= blank_q ? '0 : WORD_W'(sr_c_next);
        out_q.face_index   <= rd_face_q;
        out_q.latch_strobe <= !blank_q;
        out_q.last_word    <= (rd_face_q == 2'd3);
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_res_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  a_blank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !result_o.latch_strobe |->
      result_o.lane_a_bits == '0 && result_o.lane_b_bits == '0 &&
      result_o.lane_c_bits == '0)
    else $error("blank word carries data");

  a_last_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (result_o.last_word == (result_o.face_index == 2'd3)))
    else $error("last word flag does not match face");

  a_no_write_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q) == ST_SCAN)
    else $error("read data tagged without a scan read");

endmodule
